// ===== rtl/mkt_pkg.sv =====
// Package for the microwave keypad timer controller.
// Holds the event and mode codes, the beat types and the timer limits.
// Used by every module of the block; depends on nothing.
package mkt_pkg;

  typedef enum logic [2:0] {
    OP_DIGIT = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_RESET = 3'd3,
    OP_TICK  = 3'd4,
    OP_FAULT = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COOKING = 3'd1,
    MODE_PAUSED  = 3'd2,
    MODE_DONE    = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_e;

  localparam logic [6:0] MaxMinutes = 7'd99;
  localparam logic [5:0] MaxSeconds = 6'd59;
  localparam logic [5:0] SecsPerMin = 6'd60;
  localparam logic [3:0] MaxDigit   = 4'd9;

  // Quotient by sixty as a multiply by 1093 / 2^16, exact for totals below 1024.
  localparam logic [10:0] Div60Mul   = 11'd1093;
  localparam int unsigned Div60Shift = 16;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] digit;
  } in_t;

  typedef struct packed {
    logic [2:0] out_mode;
    logic [6:0] out_minutes;
    logic [5:0] out_seconds;
    logic       out_lamp;
  } out_t;

endpackage

// ===== rtl/mkt_in_stage.sv =====
// Input register of the microwave keypad timer controller.
// Captures one event beat and holds it until the update stage takes it.
// Depends on mkt_pkg.
module mkt_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mkt_pkg::in_t  in_data_i,
  input  logic          take_i,
  output logic          item_valid_o,
  output mkt_pkg::in_t  item_o
);

  logic         valid_q, valid_d;
  mkt_pkg::in_t data_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ===== rtl/mkt_update.sv =====
// Controller state and its next-state logic.
// Applies one event to mode, timer and lamp and presents the new state.
// Depends on mkt_pkg.
module mkt_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  mkt_pkg::in_t  item_i,
  output mkt_pkg::out_t result_o
);

  mkt_pkg::mode_e mode_q, mode_d;
  logic [6:0]     min_q, min_d;
  logic [5:0]     sec_q, sec_d;
  logic           lamp_q, lamp_d;

  logic [9:0]  total;
  logic [20:0] prod;
  logic [3:0]  quot;
  logic [9:0]  rem;
  logic [7:0]  mins_sum;
  logic [6:0]  dig_min;
  logic [5:0]  dig_sec;
  logic [6:0]  cd_min;
  logic [5:0]  cd_sec;
  logic        time_zero;

  assign time_zero = (min_q == 7'd0) && (sec_q == 6'd0);

  always_comb begin
    total    = 10'({sec_q, 3'b000}) + 10'({sec_q, 1'b0}) + 10'(item_i.digit);
    prod     = 21'(total) * 21'(mkt_pkg::Div60Mul);
    quot     = prod[mkt_pkg::Div60Shift +: 4];
    rem      = total - 10'(quot) * 10'(mkt_pkg::SecsPerMin);
    mins_sum = 8'(min_q) + 8'(quot);
    if (mins_sum > 8'(mkt_pkg::MaxMinutes)) begin
      dig_min = mkt_pkg::MaxMinutes;
      dig_sec = mkt_pkg::MaxSeconds;
    end else begin
      dig_min = mins_sum[6:0];
      dig_sec = rem[5:0];
    end
  end

  always_comb begin
    cd_min = min_q;
    cd_sec = sec_q;
    if (sec_q != 6'd0) begin
      cd_sec = sec_q - 6'd1;
    end else if (min_q != 7'd0) begin
      cd_min = min_q - 7'd1;
      cd_sec = mkt_pkg::MaxSeconds;
    end
  end

  always_comb begin
    mode_d = mode_q;
    min_d  = min_q;
    sec_d  = sec_q;
    lamp_d = lamp_q;
    if (mode_q != mkt_pkg::MODE_ERROR) begin
      case (item_i.operation)
        mkt_pkg::OP_DIGIT: begin
          if (mode_q == mkt_pkg::MODE_IDLE && item_i.digit <= mkt_pkg::MaxDigit) begin
            min_d = dig_min;
            sec_d = dig_sec;
          end
        end
        mkt_pkg::OP_START: begin
          if (!time_zero && mode_q != mkt_pkg::MODE_DONE) begin
            mode_d = mkt_pkg::MODE_COOKING;
            lamp_d = 1'b1;
          end
        end
        mkt_pkg::OP_STOP: begin
          if (mode_q == mkt_pkg::MODE_COOKING) begin
            mode_d = mkt_pkg::MODE_PAUSED;
            lamp_d = 1'b0;
          end
        end
        mkt_pkg::OP_RESET: begin
          mode_d = mkt_pkg::MODE_IDLE;
          min_d  = 7'd0;
          sec_d  = 6'd0;
          lamp_d = 1'b0;
        end
        mkt_pkg::OP_TICK: begin
          if (mode_q == mkt_pkg::MODE_COOKING) begin
            min_d = cd_min;
            sec_d = cd_sec;
            if (cd_min == 7'd0 && cd_sec == 6'd0) begin
              mode_d = mkt_pkg::MODE_DONE;
            end
          end
        end
        mkt_pkg::OP_FAULT: begin
          mode_d = mkt_pkg::MODE_ERROR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mkt_pkg::MODE_IDLE;
      min_q  <= 7'd0;
      sec_q  <= 6'd0;
      lamp_q <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
      lamp_q <= lamp_d;
    end
  end

  always_comb begin
    result_o.out_mode    = mode_d;
    result_o.out_minutes = min_d;
    result_o.out_seconds = sec_d;
    result_o.out_lamp    = lamp_d;
  end

endmodule

// ===== rtl/mkt_out_stage.sv =====
// Result register of the microwave keypad timer controller.
// Holds one result beat until the consumer takes it.
// Depends on mkt_pkg.
module mkt_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mkt_pkg::out_t result_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mkt_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  mkt_pkg::out_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/microwave_keypad_timer_controller_unit.sv =====
// Microwave keypad timer controller: one result beat per event beat.
// The result beat is registered in the output stage after its event beat has passed the input stage.
// Throughput is one event per cycle while the consumer takes results; the mode and timer update is combinational.
// Reset is asynchronous and active low: idle, 00:00, lamp off, both stages empty.
// Depends on mkt_pkg, mkt_in_stage, mkt_update and mkt_out_stage.
module microwave_keypad_timer_controller_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mkt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mkt_pkg::out_t out_data_o
);

  logic          item_valid;
  mkt_pkg::in_t  item;
  logic          out_free;
  logic          fire;
  mkt_pkg::out_t result;

  assign fire = item_valid && out_free;

  mkt_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mkt_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  mkt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/mkt_checker.sv =====
// Port-level checks for the microwave keypad timer controller.
// Bound to the top level; depends on mkt_pkg.
module mkt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mkt_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result beat changed while stalled.");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_minutes <= mkt_pkg::MaxMinutes &&
                    out_data_o.out_seconds <= mkt_pkg::MaxSeconds)
    else $error("Timer out of range.");

  a_lamp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_mode == mkt_pkg::MODE_IDLE ||
                    out_data_o.out_mode == mkt_pkg::MODE_PAUSED)
    |-> !out_data_o.out_lamp)
    else $error("Lamp on while idle or paused.");

  a_cooking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_mode == mkt_pkg::MODE_COOKING
    |-> out_data_o.out_lamp &&
        (out_data_o.out_minutes != 7'd0 || out_data_o.out_seconds != 6'd0))
    else $error("Cooking with lamp off or timer at zero.");

endmodule

bind microwave_keypad_timer_controller_unit mkt_checker u_mkt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/microwave_keypad_timer_controller_unit_tb.sv =====
// Testbench for microwave_keypad_timer_controller_unit: keypad and tick events in,
// mode, timer and lamp state out, checked beat by beat against an in-bench predictor.
// Depends on mkt_pkg and the unit under test.
`timescale 1ns / 100ps

module microwave_keypad_timer_controller_unit_tb;
  import mkt_pkg::*;

  localparam logic [2:0] OpSpare6      = 3'd6;
  localparam logic [2:0] OpSpare7      = 3'd7;
  localparam int         ItemsPerPhase = 320;
  localparam int         WatchdogLimit = 2000;
  localparam int         HoldCycles    = 120;
  localparam int         HoldAfterBeat = 60;
  localparam int         DrainCycles   = 8;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  microwave_keypad_timer_controller_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  in_t        keypad_q[$];
  out_t       display_q[$];
  int         events_queued = 0;
  int         errors = 0;
  int         beats_seen = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;

  mode_e      oven_mode = MODE_IDLE;
  logic [6:0] min_left  = '0;
  logic [5:0] sec_left  = '0;
  logic       lamp      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_t oven_next(in_t ev);
    int unsigned total;
    int unsigned mins;
    int unsigned secs;
    out_t        res;
    if (oven_mode != MODE_ERROR) begin
      case (ev.operation)
        OP_DIGIT: begin
          if (oven_mode == MODE_IDLE && ev.digit <= MaxDigit) begin
            total = sec_left * 10 + ev.digit;
            mins  = min_left + total / SecsPerMin;
            secs  = total % SecsPerMin;
            if (mins > MaxMinutes) begin
              mins = MaxMinutes;
              secs = MaxSeconds;
            end
            min_left = mins[6:0];
            sec_left = secs[5:0];
          end
        end
        OP_START: begin
          if ((min_left != 0 || sec_left != 0) && oven_mode != MODE_DONE) begin
            oven_mode = MODE_COOKING;
            lamp      = 1'b1;
          end
        end
        OP_STOP: begin
          if (oven_mode == MODE_COOKING) begin
            oven_mode = MODE_PAUSED;
            lamp      = 1'b0;
          end
        end
        OP_RESET: begin
          oven_mode = MODE_IDLE;
          min_left  = '0;
          sec_left  = '0;
          lamp      = 1'b0;
        end
        OP_TICK: begin
          if (oven_mode == MODE_COOKING) begin
            if (sec_left != 0) begin
              sec_left = sec_left - 1'b1;
            end else if (min_left != 0) begin
              min_left = min_left - 1'b1;
              sec_left = MaxSeconds;
            end
            if (min_left == 0 && sec_left == 0) begin
              oven_mode = MODE_DONE;
            end
          end
        end
        OP_FAULT: oven_mode = MODE_ERROR;
        default: ;
      endcase
    end
    res.out_mode    = oven_mode;
    res.out_minutes = min_left;
    res.out_seconds = sec_left;
    res.out_lamp    = lamp;
    return res;
  endfunction

  task automatic add_event(logic [2:0] op, logic [3:0] d);
    in_t ev;
    ev.operation = op;
    ev.digit     = d;
    keypad_q.push_back(ev);
    events_queued++;
  endtask

  function automatic logic [3:0] any_digit();
    return 4'($urandom_range(15));
  endfunction

  task automatic add_noise();
    logic [2:0] op;
    op = 3'($urandom_range(7));
    if (op == OP_FAULT) begin
      op = OpSpare6;
    end
    add_event(op, any_digit());
  endtask

  task automatic add_program();
    int n_digits;
    int n_ticks;
    if ($urandom_range(5) != 0) begin
      add_event(OP_RESET, any_digit());
    end
    n_digits = ($urandom_range(9) == 0) ? $urandom_range(16, 22) : $urandom_range(1, 2);
    for (int i = 0; i < n_digits; i++) begin
      if ($urandom_range(7) == 0) begin
        add_event(OP_DIGIT, 4'($urandom_range(10, 15)));
      end else begin
        add_event(OP_DIGIT, 4'($urandom_range(9)));
      end
    end
    add_event(OP_START, any_digit());
    n_ticks = $urandom_range(0, 30);
    for (int i = 0; i < n_ticks; i++) begin
      case ($urandom_range(15))
        0: begin
          add_event(OP_STOP, any_digit());
          if ($urandom_range(1) == 0) begin
            add_event(OP_TICK, any_digit());
          end
          add_event(OP_START, any_digit());
        end
        1: add_noise();
        default: add_event(OP_TICK, any_digit());
      endcase
    end
    if ($urandom_range(3) == 0) begin
      add_event(OP_START, any_digit());
      add_event(OP_STOP, any_digit());
    end
  endtask

  task automatic add_random_phase();
    int target;
    target = events_queued + ItemsPerPhase;
    while (events_queued < target) begin
      add_program();
    end
  endtask

  task automatic drain_inputs();
    while (keypad_q.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        display_q.push_back(oven_next(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (keypad_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= keypad_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      beats_seen <= 0;
    end else if (out_valid_o && out_ready_i) begin
      beats_seen <= beats_seen + 1;
      if (display_q.size() == 0) begin
        $error("unexpected result beat: mode %0d time %0d:%0d lamp %0d",
               out_data_o.out_mode, out_data_o.out_minutes, out_data_o.out_seconds,
               out_data_o.out_lamp);
        errors++;
      end else begin
        want = display_q.pop_front();
        if (out_data_o.out_mode !== want.out_mode) begin
          $error("out_mode expected %0d got %0d", want.out_mode, out_data_o.out_mode);
          errors++;
        end
        if (out_data_o.out_minutes !== want.out_minutes) begin
          $error("out_minutes expected %0d got %0d", want.out_minutes,
                 out_data_o.out_minutes);
          errors++;
        end
        if (out_data_o.out_seconds !== want.out_seconds) begin
          $error("out_seconds expected %0d got %0d", want.out_seconds,
                 out_data_o.out_seconds);
          errors++;
        end
        if (out_data_o.out_lamp !== want.out_lamp) begin
          $error("out_lamp expected %0d got %0d", want.out_lamp, out_data_o.out_lamp);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && beats_seen >= HoldAfterBeat) begin
      out_ready_i <= 1'b0;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase one: no idling, directed walk through the mode machine, then random programs.
    add_event(OP_START, 4'd0);
    add_event(OP_DIGIT, 4'd15);
    add_event(OpSpare7, 4'd15);
    add_event(OpSpare6, 4'd0);
    add_event(OP_DIGIT, 4'd6);
    add_event(OP_DIGIT, 4'd0);
    add_event(OP_START, 4'd9);
    add_event(OP_DIGIT, 4'd9);
    add_event(OP_TICK, 4'd0);
    add_event(OP_STOP, 4'd0);
    add_event(OP_TICK, 4'd0);
    add_event(OP_DIGIT, 4'd3);
    add_event(OP_START, 4'd0);
    add_event(OP_RESET, 4'd0);
    add_event(OP_DIGIT, 4'd2);
    add_event(OP_START, 4'd0);
    add_event(OP_TICK, 4'd0);
    add_event(OP_TICK, 4'd0);
    add_event(OP_TICK, 4'd0);
    add_event(OP_START, 4'd0);
    add_event(OP_STOP, 4'd0);
    add_event(OP_DIGIT, 4'd9);
    add_random_phase();
    drain_inputs();

    src_idle_pct   = 64;
    sink_stall_pct = 0;
    add_random_phase();
    drain_inputs();

    src_idle_pct   = 0;
    sink_stall_pct = 64;
    add_random_phase();
    drain_inputs();

    // Last phase ends with a fault, after which every event must be ignored.
    src_idle_pct   = 36;
    sink_stall_pct = 36;
    add_random_phase();
    add_event(OP_RESET, 4'd0);
    add_event(OP_DIGIT, 4'd5);
    add_event(OP_START, 4'd0);
    add_event(OP_FAULT, 4'd0);
    add_event(OP_RESET, 4'd0);
    add_event(OP_START, 4'd0);
    add_event(OP_TICK, 4'd0);
    add_event(OP_STOP, 4'd0);
    add_event(OP_DIGIT, 4'd3);
    add_event(OP_FAULT, 4'd0);
    drain_inputs();

    while (display_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0 && display_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
